/* rtl/arpe_pkg.sv */
package arpe_pkg;

  // frame kind codes on the result channel
  typedef enum logic [1:0] {
    KIND_ARP   = 2'd0,
    KIND_ICMP  = 2'd1,
    KIND_OTHER = 2'd2
  } kind_t;

  // front sequencer states
  typedef enum logic [1:0] {
    ST_RUN,
    ST_SETTLE,
    ST_FLUSH
  } fstate_t;

  // configuration register select (paddr bit 3)
  localparam logic REG_OWN_MAC = 1'b0;
  localparam logic REG_OWN_IP  = 1'b1;

  localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_PROTO_ICMP = 8'h01;
  localparam logic [7:0]  IP_VER_IHL    = 8'h45;
  localparam logic [7:0]  IP_TTL        = 8'h40;
  localparam logic [15:0] IP_W0         = 16'h4500;
  localparam logic [15:0] IP_TTL_PROTO  = 16'h4001;
  localparam logic [15:0] ETH_HDR_LEN   = 16'd14;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // header fields captured from the frame in flight
  typedef struct packed {
    logic [47:0] src_mac;
    logic [47:0] snd_mac;
    logic [31:0] snd_ip;
    logic [31:0] src_ip;
    logic [15:0] type_word;
    logic [7:0]  proto;
    logic [31:0] icmp_words;
    logic [11:0] held_len;
  } caps_t;

  // one result beat
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    kind_t      kind;
  } beat_t;

  function automatic kind_t kind_of(caps_t c);
    kind_t k;
    k = KIND_OTHER;
    if (c.type_word == ETH_TYPE_ARP) k = KIND_ARP;
    else if (c.type_word == ETH_TYPE_IPV4 && c.proto == IP_PROTO_ICMP) k = KIND_ICMP;
    return k;
  endfunction

  function automatic logic [7:0] byte48(logic [47:0] v, logic [2:0] k);
    return v[8*k +: 8];
  endfunction

  function automatic logic [7:0] byte32(logic [31:0] v, logic [1:0] k);
    return v[8*k +: 8];
  endfunction

  function automatic logic [7:0] arp_head(logic [2:0] i);
    logic [7:0] b;
    unique case (i)
      3'd1:    b = 8'h01;
      3'd2:    b = 8'h08;
      3'd4:    b = 8'h06;
      3'd5:    b = 8'h04;
      3'd7:    b = 8'h02;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // ip header checksum, ones-complement sum seeded with all ones
  function automatic logic [15:0] ip_csum(logic [11:0] held, logic [31:0] own_ip,
                                          logic [31:0] src_ip);
    logic [15:0] len;
    logic [18:0] s;
    logic [16:0] t;
    logic [15:0] r;
    len = {4'b0, held} - ETH_HDR_LEN;
    s = 19'h0FFFF + {3'b0, IP_W0} + {3'b0, len} + {3'b0, IP_TTL_PROTO}
      + {3'b0, own_ip[31:16]} + {3'b0, own_ip[15:0]}
      + {3'b0, src_ip[31:16]} + {3'b0, src_ip[15:0]};
    t = {1'b0, s[15:0]} + {14'b0, s[18:16]};
    r = t[15:0] + {15'b0, t[16]};
    return ~r;
  endfunction

  // icmp checksum update from the old type/code word and the old checksum
  function automatic logic [15:0] icmp_csum(logic [31:0] w);
    logic [16:0] t;
    logic [15:0] s;
    t = {1'b0, ~w[15:0]} + {1'b0, ~w[31:16]};
    if (t > 17'h0FFFF) s = t[15:0] + 16'd1;
    else s = t[15:0];
    return ~s;
  endfunction

endpackage

/* rtl/arpe_in_if.sv */
interface arpe_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [11:0] frame_length;
  logic        last_in;

  modport source (output valid, data_byte, frame_length, last_in, input ready);
  modport sink (input valid, data_byte, frame_length, last_in, output ready);
endinterface

/* rtl/arpe_out_if.sv */
interface arpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic [1:0] frame_kind;

  modport source (output valid, out_byte, out_last, frame_kind, input ready);
  modport sink (input valid, out_byte, out_last, frame_kind, output ready);
endinterface

/* rtl/arpe_rewrite.sv */
module arpe_rewrite
  import arpe_pkg::*;
#(
  parameter int POS_W = 12
) (
  input  logic [POS_W-1:0] pos,
  input  logic [7:0]       data,
  input  logic [47:0]      own_mac,
  input  logic [31:0]      own_ip,
  input  caps_t            caps,
  input  logic [15:0]      csum_ip,
  output logic [7:0]       data_out
);

  logic [5:0]  p6;
  logic        hdr;
  kind_t       kind;
  logic [15:0] len;
  logic [15:0] csum_icmp;

  assign p6        = pos[5:0];
  assign hdr       = (pos < POS_W'(42));
  assign kind      = kind_of(caps);
  assign len       = {4'b0, caps.held_len} - ETH_HDR_LEN;
  assign csum_icmp = icmp_csum(caps.icmp_words);

  // per-position byte substitution over the first 42 bytes
  always_comb begin
    data_out = data;
    if (hdr) begin
      priority if (p6 < 6'd6) begin
        data_out = byte48(caps.src_mac, 3'(6'd5 - p6));
      end else if (p6 < 6'd12) begin
        data_out = byte48(own_mac, 3'(6'd11 - p6));
      end else if (p6 < 6'd14) begin
        data_out = data;
      end else if (kind == KIND_ARP) begin
        priority if (p6 < 6'd22) data_out = arp_head(3'(p6 - 6'd14));
        else if (p6 < 6'd28) data_out = byte48(own_mac, 3'(6'd27 - p6));
        else if (p6 < 6'd32) data_out = byte32(own_ip, 2'(6'd31 - p6));
        else if (p6 < 6'd38) data_out = byte48(caps.snd_mac, 3'(6'd37 - p6));
        else data_out = byte32(caps.snd_ip, 2'(6'd41 - p6));
      end else if (kind == KIND_ICMP) begin
        priority if (p6 == 6'd14) data_out = IP_VER_IHL;
        else if (p6 == 6'd16) data_out = len[15:8];
        else if (p6 == 6'd17) data_out = len[7:0];
        else if (p6 == 6'd22) data_out = IP_TTL;
        else if (p6 == 6'd23) data_out = IP_PROTO_ICMP;
        else if (p6 == 6'd24) data_out = csum_ip[15:8];
        else if (p6 == 6'd25) data_out = csum_ip[7:0];
        else if (p6 == 6'd36) data_out = csum_icmp[15:8];
        else if (p6 == 6'd37) data_out = csum_icmp[7:0];
        else if (p6 == 6'd15 || (p6 >= 6'd18 && p6 < 6'd22) || p6 == 6'd34 || p6 == 6'd35)
          data_out = 8'h00;
        else if (p6 >= 6'd26 && p6 < 6'd30) data_out = byte32(own_ip, 2'(6'd29 - p6));
        else if (p6 >= 6'd30 && p6 < 6'd34) data_out = byte32(caps.src_ip, 2'(6'd33 - p6));
        else data_out = data;
      end else begin
        data_out = data;
      end
    end
  end

endmodule

/* rtl/arpe_front.sv */
module arpe_front
  import arpe_pkg::*;
#(
  parameter int MAX_FRAME = 2048,
  parameter int LAG       = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  arpe_in_if.sink     in_ch,
  input  logic [47:0] own_mac,
  input  logic [31:0] own_ip,
  input  logic        fifo_full,
  output logic        push,
  output beat_t       push_beat
);

  localparam int POS_W  = $clog2(MAX_FRAME + 1);
  localparam int FILL_W = $clog2(LAG + 1);
  localparam int IDX_W  = $clog2(LAG);

  fstate_t           state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  fpos_r, fpos_nxt;
  logic [FILL_W-1:0] fcnt_r, fcnt_nxt;
  logic [7:0]        dl_r [LAG];
  logic [7:0]        dl_nxt [LAG];
  logic [7:0]        dl_shift [LAG];
  caps_t             caps_r, caps_nxt, caps_in;
  logic [15:0]       csum_r;
  logic              acc;
  logic              full_line;
  logic [FILL_W-1:0] fill, fill_after;
  logic [5:0]        p6;
  logic              lo;
  logic [7:0]        b;
  logic [POS_W-1:0]  rw_pos;
  caps_t             rw_caps;
  logic [7:0]        rw_byte;

  assign in_ch.ready = (state_r == ST_RUN) && !fifo_full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign full_line   = (pos_r >= POS_W'(LAG));
  assign fill        = full_line ? FILL_W'(LAG) : FILL_W'(pos_r);
  assign fill_after  = full_line ? FILL_W'(LAG) : fill + FILL_W'(1);
  assign p6          = pos_r[5:0];
  assign lo          = (pos_r < POS_W'(64));

  // header capture for the incoming byte
  always_comb begin
    caps_in = caps_r;
    if (pos_r == '0) begin
      caps_in = '0;
      caps_in.held_len = in_ch.frame_length;
    end
    caps_nxt = caps_in;
    if (lo) begin
      if (p6 >= 6'd6 && p6 < 6'd12) caps_nxt.src_mac = {caps_in.src_mac[39:0], b};
      if (p6 == 6'd12 || p6 == 6'd13) caps_nxt.type_word = {caps_in.type_word[7:0], b};
      if (p6 == 6'd23) caps_nxt.proto = b;
      if (p6 >= 6'd22 && p6 < 6'd28) caps_nxt.snd_mac = {caps_in.snd_mac[39:0], b};
      if (p6 >= 6'd28 && p6 < 6'd32) caps_nxt.snd_ip = {caps_in.snd_ip[23:0], b};
      if (p6 >= 6'd26 && p6 < 6'd30) caps_nxt.src_ip = {caps_in.src_ip[23:0], b};
      if (p6 >= 6'd34 && p6 < 6'd38) caps_nxt.icmp_words = {caps_in.icmp_words[23:0], b};
    end
  end

  // delay line: fill in order, then shift one byte per beat
  always_comb begin
    for (int i = 0; i < LAG - 1; i++) dl_shift[i] = dl_r[i+1];
    dl_shift[LAG-1] = 8'h00;
    dl_nxt = dl_r;
    if (full_line) begin
      for (int i = 0; i < LAG - 1; i++) dl_nxt[i] = dl_r[i+1];
      dl_nxt[LAG-1] = b;
    end else begin
      dl_nxt[fill[IDX_W-1:0]] = b;
    end
  end

  // rewrite source: live byte stream in run, held frame while flushing
  assign rw_pos  = (state_r == ST_RUN) ? pos_r - POS_W'(LAG) : fpos_r;
  assign rw_caps = (state_r == ST_RUN) ? caps_nxt : caps_r;

  arpe_rewrite #(
    .POS_W(POS_W)
  ) u_rewrite (
    .pos      (rw_pos),
    .data     (dl_r[0]),
    .own_mac  (own_mac),
    .own_ip   (own_ip),
    .caps     (rw_caps),
    .csum_ip  (csum_r),
    .data_out (rw_byte)
  );

  // sequencer next state and outputs
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    fpos_nxt  = fpos_r;
    fcnt_nxt  = fcnt_r;
    push      = 1'b0;
    push_beat.data = rw_byte;
    push_beat.last = 1'b0;
    push_beat.kind = KIND_ARP;
    unique case (state_r)
      ST_RUN: begin
        if (acc) begin
          push = full_line;
          if (in_ch.last_in) begin
            state_nxt = ST_SETTLE;
            pos_nxt   = '0;
            fcnt_nxt  = fill_after;
            fpos_nxt  = pos_r + POS_W'(1) - POS_W'(fill_after);
          end else if (pos_r < POS_W'(MAX_FRAME)) begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end
      end
      ST_SETTLE: begin
        state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!fifo_full) begin
          push     = 1'b1;
          fcnt_nxt = fcnt_r - FILL_W'(1);
          fpos_nxt = fpos_r + POS_W'(1);
          if (fcnt_r == FILL_W'(1)) begin
            push_beat.last = 1'b1;
            push_beat.kind = kind_of(caps_r);
            state_nxt      = ST_RUN;
          end
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      pos_r   <= '0;
      fcnt_r  <= '0;
      caps_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      fcnt_r  <= fcnt_nxt;
      if (acc) caps_r <= caps_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    fpos_r <= fpos_nxt;
    csum_r <= ip_csum(caps_r.held_len, own_ip, caps_r.src_ip);
    if (acc) dl_r <= dl_nxt;
    else if (state_r == ST_FLUSH && !fifo_full) dl_r <= dl_shift;
  end

endmodule

/* rtl/arpe_fifo.sv */
module arpe_fifo
  import arpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  beat_t      push_beat,
  output logic       full,
  arpe_out_if.source out_ch
);

  beat_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_r, rd_r;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               pop;
  beat_t              head;

  assign full   = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop    = out_ch.valid && out_ch.ready;
  assign head   = mem_r[rd_r];

  assign out_ch.valid      = (cnt_r != '0);
  assign out_ch.out_byte   = head.data;
  assign out_ch.out_last   = head.last;
  assign out_ch.frame_kind = head.kind;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + (FIFO_AW+1)'(1);
    else if (pop && !push) cnt_nxt = cnt_r - (FIFO_AW+1)'(1);
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= wr_r + FIFO_AW'(1);
      if (pop) rd_r <= rd_r + FIFO_AW'(1);
    end
  end

  // beat storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_beat;
  end

endmodule

/* rtl/arp_icmp_echo_responder_core.sv */
// channel  dir  beat contents
// in_ch    in   data_byte, frame_length, last_in
// out_ch   out  out_byte, out_last, frame_kind
// cfg_*    in   apb writes/reads of own_mac (0x0) and own_ip (0x8)
//
// one input byte per cycle while a frame streams and the queue is not full; each reply
// byte leaves LAG bytes later. after the closing byte come a checksum settle state, then
// the held delay line draining one byte a cycle while not full; in_ch.ready stays low
// a 4-beat queue parts the front from out_ch, so output stalls back up into in_ch.ready
// rst_n is synchronous, active low; no clearing pass
module arp_icmp_echo_responder_core
  import arpe_pkg::*;
#(
  parameter int MAX_FRAME = 2048,
  parameter int LAG       = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  arpe_in_if.sink     in_ch,
  arpe_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [47:0] own_mac_r;
  logic [31:0] own_ip_r;
  logic        wr_en;
  logic        fifo_full;
  logic        push;
  beat_t       push_beat;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r <= '0;
      own_ip_r  <= '0;
    end else if (wr_en) begin
      unique case (cfg_paddr[3])
        REG_OWN_MAC: own_mac_r <= cfg_pwdata[47:0];
        REG_OWN_IP:  own_ip_r  <= cfg_pwdata[31:0];
        default:     own_ip_r  <= own_ip_r;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (cfg_paddr[3])
      REG_OWN_MAC: cfg_prdata = {16'b0, own_mac_r};
      REG_OWN_IP:  cfg_prdata = {32'b0, own_ip_r};
      default:     cfg_prdata = '0;
    endcase
  end

  arpe_front #(
    .MAX_FRAME(MAX_FRAME),
    .LAG      (LAG)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .own_mac   (own_mac_r),
    .own_ip    (own_ip_r),
    .fifo_full (fifo_full),
    .push      (push),
    .push_beat (push_beat)
  );

  arpe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_beat (push_beat),
    .full      (fifo_full),
    .out_ch    (out_ch)
  );

endmodule

/* verif/arpe_reply_checker.sv */
`timescale 1ns / 1ps
module arpe_reply_checker
  import arpe_pkg::*;
#(
  parameter int MAX_FRAME = 2048,
  parameter int LAG       = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data,
  input  logic [11:0] in_len,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_data,
  input  logic        out_last,
  input  logic [1:0]  out_kind,
  input  logic [47:0] mac_reg,
  input  logic [31:0] ip_reg,
  output int          fail_count,
  output int          pending
);

  // predictor state
  logic [7:0]  dline [LAG];
  int          pos_q;
  logic [11:0] held_len;
  logic [47:0] src_mac, snd_mac;
  logic [31:0] snd_ip, src_ip, icmp_w;
  logic [15:0] type_w;
  logic [7:0]  proto;
  beat_t       reply_q [$];

  assign pending = reply_q.size();

  function automatic logic [15:0] oc_add(logic [15:0] a, logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, w};
    if (s > 17'h0FFFF) s = s - 17'h0FFFF;
    return s[15:0];
  endfunction

  function automatic kind_t frame_kind_now();
    if (type_w == ETH_TYPE_ARP) return KIND_ARP;
    if (type_w == ETH_TYPE_IPV4 && proto == IP_PROTO_ICMP) return KIND_ICMP;
    return KIND_OTHER;
  endfunction

  function automatic logic [15:0] hdr_csum();
    logic [15:0] a;
    logic [15:0] len;
    len = {4'b0, held_len} - 16'd14;
    a = 16'hFFFF;
    a = oc_add(a, 16'h4500);
    a = oc_add(a, len);
    a = oc_add(a, 16'h4001);
    a = oc_add(a, ip_reg[31:16]);
    a = oc_add(a, ip_reg[15:0]);
    a = oc_add(a, src_ip[31:16]);
    a = oc_add(a, src_ip[15:0]);
    return ~a;
  endfunction

  function automatic logic [15:0] echo_csum();
    return ~oc_add(~icmp_w[15:0], ~icmp_w[31:16]);
  endfunction

  // rewritten byte at frame position p
  function automatic logic [7:0] rewrite_byte(int p, logic [7:0] b);
    logic [15:0] len;
    len = {4'b0, held_len} - 16'd14;
    if (p < 6) return 8'(src_mac >> (8 * (5 - p)));
    if (p < 12) return 8'(mac_reg >> (8 * (11 - p)));
    if (p < 14) return b;
    case (frame_kind_now())
      KIND_ARP: begin
        if (p < 22) begin
          case (p - 14)
            1: return 8'h01;
            2: return 8'h08;
            4: return 8'h06;
            5: return 8'h04;
            7: return 8'h02;
            default: return 8'h00;
          endcase
        end
        if (p < 28) return 8'(mac_reg >> (8 * (27 - p)));
        if (p < 32) return 8'(ip_reg >> (8 * (31 - p)));
        if (p < 38) return 8'(snd_mac >> (8 * (37 - p)));
        if (p < 42) return 8'(snd_ip >> (8 * (41 - p)));
        return b;
      end
      KIND_ICMP: begin
        if (p == 14) return IP_VER_IHL;
        if (p == 16) return len[15:8];
        if (p == 17) return len[7:0];
        if (p == 22) return IP_TTL;
        if (p == 23) return IP_PROTO_ICMP;
        if (p == 24) return 8'(hdr_csum() >> 8);
        if (p == 25) return 8'(hdr_csum());
        if (p == 36) return 8'(echo_csum() >> 8);
        if (p == 37) return 8'(echo_csum());
        if (p == 15 || (p >= 18 && p < 22) || p == 34 || p == 35) return 8'h00;
        if (p >= 26 && p < 30) return 8'(ip_reg >> (8 * (29 - p)));
        if (p >= 30 && p < 34) return 8'(src_ip >> (8 * (33 - p)));
        return b;
      end
      default: return b;
    endcase
  endfunction

  // predict on each accepted input beat
  always @(posedge clk) begin
    int fill, base;
    beat_t r;
    if (!rst_n) begin
      pos_q <= 0;
      for (int i = 0; i < LAG; i++) dline[i] = 8'h00;
      reply_q.delete();
    end else if (in_valid && in_ready) begin
      fill = pos_q < LAG ? pos_q : LAG;
      if (pos_q == 0) begin
        src_mac = '0; snd_mac = '0; snd_ip = '0; src_ip = '0;
        type_w = '0; proto = '0; icmp_w = '0;
        held_len = in_len;
      end
      if (pos_q >= 6 && pos_q < 12) src_mac = {src_mac[39:0], in_data};
      if (pos_q == 12 || pos_q == 13) type_w = {type_w[7:0], in_data};
      if (pos_q == 23) proto = in_data;
      if (pos_q >= 22 && pos_q < 28) snd_mac = {snd_mac[39:0], in_data};
      if (pos_q >= 28 && pos_q < 32) snd_ip = {snd_ip[23:0], in_data};
      if (pos_q >= 26 && pos_q < 30) src_ip = {src_ip[23:0], in_data};
      if (pos_q >= 34 && pos_q < 38) icmp_w = {icmp_w[23:0], in_data};
      if (fill == LAG) begin
        r.data = rewrite_byte(pos_q - LAG, dline[0]);
        r.last = 1'b0;
        r.kind = KIND_ARP;
        reply_q.push_back(r);
        for (int i = 0; i < LAG - 1; i++) dline[i] = dline[i + 1];
        dline[LAG - 1] = in_data;
      end else begin
        dline[fill] = in_data;
        fill++;
      end
      if (in_last) begin
        base = pos_q + 1 - fill;
        for (int i = 0; i < fill; i++) begin
          r.data = rewrite_byte(base + i, dline[i]);
          r.last = (i + 1 == fill);
          r.kind = (i + 1 == fill) ? frame_kind_now() : KIND_ARP;
          reply_q.push_back(r);
        end
        for (int i = 0; i < LAG; i++) dline[i] = 8'h00;
        pos_q <= 0;
      end else begin
        pos_q <= pos_q < MAX_FRAME ? pos_q + 1 : pos_q;
      end
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    beat_t want;
    if (!rst_n) begin
      fail_count <= 0;
    end else if (out_valid && out_ready) begin
      if (reply_q.size() == 0) begin
        if (fail_count < 10) $display("unexpected reply beat %h", out_data);
        fail_count <= fail_count + 1;
      end else begin
        want = reply_q.pop_front();
        if (want.data !== out_data || want.last !== out_last || want.kind !== out_kind) begin
          if (fail_count < 10)
            $display("reply mismatch: want %h/%b/%0d got %h/%b/%0d",
                     want.data, want.last, want.kind, out_data, out_last, out_kind);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
module tb;
  import arpe_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;
  logic [47:0] mac_shadow = '0;
  logic [31:0] ip_shadow = '0;
  int          fail_count, pending, cycles = 0;
  int          items_sent = 0;
  bit          hold_out = 1'b0;

  arpe_in_if  in_ch ();
  arpe_out_if out_ch ();

  arp_icmp_echo_responder_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  arpe_reply_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data_byte),
    .in_len(in_ch.frame_length), .in_last(in_ch.last_in),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.out_byte),
    .out_last(out_ch.out_last), .out_kind(out_ch.frame_kind),
    .mac_reg(mac_shadow), .ip_reg(ip_shadow),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n || hold_out) out_ch.ready <= 1'b0;
    else if ($urandom_range(0, 3) == 0) out_ch.ready <= ~out_ch.ready;
    else if ($urandom_range(0, 30) == 0) out_ch.ready <= 1'b0;
    else out_ch.ready <= 1'b1;
  end

  // generous cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("arp_icmp_echo_responder_core regression: fail");
      $finish;
    end
  end

  // apb write, then shadow the value for the checker
  task automatic reg_write(logic addr_sel, logic [63:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {addr_sel, 3'b000}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (addr_sel == REG_OWN_MAC) mac_shadow = val[47:0];
    else ip_shadow = val[31:0];
  endtask

  // let the checker see the last accepted beat before looking at pending
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // one frame beat with a random gap before it
  task automatic send_byte(logic [7:0] b, logic [11:0] len, logic last);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.frame_length <= len;
    in_ch.last_in <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // kind: 0 arp, 1 icmp, 2 ipv4 other proto, 3 random; nbytes may be short
  task automatic send_frame(int kind, int nbytes, logic [11:0] len);
    logic [7:0] b;
    for (int p = 0; p < nbytes; p++) begin
      b = $urandom_range(0, 255);
      if (p == 12 && kind != 3) b = 8'h08;
      if (p == 13 && kind == 0) b = 8'h06;
      if (p == 13 && (kind == 1 || kind == 2)) b = 8'h00;
      if (p == 23 && kind == 1) b = 8'h01;
      if (p == 23 && kind == 2 && b == 8'h01) b = 8'h11;
      send_byte(b, len, p == nbytes - 1);
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic rand_frame();
    int k, n;
    k = $urandom_range(0, 3);
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 41) : $urandom_range(42, 64);
    send_frame(k, n, ($urandom_range(0, 5) == 0) ? 12'($urandom_range(0, 4095)) : 12'(n));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.frame_length = '0;
    in_ch.last_in = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    reg_write(REG_OWN_MAC, 64'h0);
    reg_write(REG_OWN_IP, 64'h0);

    // directed: extremes, each kind, short frames, tiny length
    send_frame(0, 42, 12'd42);
    send_frame(1, 42, 12'd0);
    send_frame(1, 1, 12'hFFF);
    send_frame(3, 12, 12'd14);
    wait_drained();

    reg_write(REG_OWN_MAC, 64'hFFFF_FFFF_FFFF);
    reg_write(REG_OWN_IP, 64'hFFFF_FFFF);
    send_frame(1, 44, 12'd2048);
    send_frame(2, 30, 12'd13);
    send_frame(0, 11, 12'd11);

    // long receiver hold-off while the sender keeps going
    fork
      begin
        hold_out = 1'b1;
        repeat (120) @(posedge clk);
        hold_out = 1'b0;
      end
      send_frame(1, 50, 12'd50);
    join
    wait_drained();

    // random phases with new settings
    for (int ph = 0; ph < 3; ph++) begin
      reg_write(REG_OWN_MAC, {$urandom, $urandom});
      reg_write(REG_OWN_IP, 64'($urandom));
      while (items_sent < 240 + ph * 12) rand_frame();
      wait_drained();
    end

    if (fail_count == 0) $display("arp_icmp_echo_responder_core regression: pass");
    else $display("arp_icmp_echo_responder_core regression: fail");
    $finish;
  end

endmodule
